/* design/motor_feedback_multiturn_tracker_defines.svh */
// Assertion macros for the multi-turn tracker. Each macro expects signals
// named clk and rst_n in the scope where it is used.
`ifndef MOTOR_FEEDBACK_MULTITURN_TRACKER_DEFINES_SVH
`define MOTOR_FEEDBACK_MULTITURN_TRACKER_DEFINES_SVH

`ifndef SYNTHESIS

`define MFT_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define MFT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define MFT_ASSERT_SAME(lbl, ante, cons)

`define MFT_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

/* design/mft_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package mft_pkg;

  localparam int unsigned PosW   = 16;
  localparam int unsigned TurnW  = 32;
  localparam int unsigned AngleW = 46;

  typedef logic [PosW-1:0]          pos_t;
  typedef logic signed [TurnW-1:0]  turns_t;
  typedef logic signed [AngleW-1:0] angle_t;

  // Tracker state as seen by the frame that caused it.
  typedef struct packed {
    turns_t turns;
    pos_t   zero_offset;
  } track_t;

endpackage

`default_nettype wire

/* design/mft_unwrap.sv */
`timescale 1ns / 1ps
`default_nettype none

module mft_unwrap import mft_pkg::*; #(
  parameter int unsigned COUNTS_PER_TURN = 8192
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   en,
  input  wire pos_t   pos,
  output track_t      trk
);

  localparam logic signed [PosW:0] HalfTurn = (PosW+1)'(COUNTS_PER_TURN / 2);

  pos_t   prev_pos_r;
  pos_t   offset_r,   offset_nxt;
  logic   captured_r;
  turns_t turns_r,    turns_nxt;
  logic signed [PosW:0] step;

  assign step = $signed({1'b0, pos}) - $signed({1'b0, prev_pos_r});

  always_comb begin
    offset_nxt = offset_r;
    turns_nxt  = turns_r;
    if (!captured_r) begin
      offset_nxt = pos;
    end else if (step > HalfTurn) begin
      turns_nxt = turns_r - TurnW'(1);
    end else if (step < -HalfTurn) begin
      turns_nxt = turns_r + TurnW'(1);
    end
  end

  // The frame sees the state it leaves behind.
  assign trk.turns       = turns_nxt;
  assign trk.zero_offset = offset_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_pos_r <= '0;
      offset_r   <= '0;
      captured_r <= 1'b0;
      turns_r    <= '0;
    end else if (en) begin
      prev_pos_r <= pos;
      offset_r   <= offset_nxt;
      captured_r <= 1'b1;
      turns_r    <= turns_nxt;
    end
  end

endmodule

`default_nettype wire

/* design/motor_feedback_multiturn_tracker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "motor_feedback_multiturn_tracker_defines.svh"
//
//  Channel  Direction  Handshake          Payload
//  in_      input      in_valid/in_ready  seven feedback frame bytes
//  out_     output     out_valid/out_ready unpacked words, turn count, angle
//
//  One frame per cycle is accepted while the output is not stalled; each
//  result goes through stage one, then the output register. Turn tracking
//  feeds stage one; the turn multiply and angle sum feed the output register.
//  A synchronous low rst_n clears the offset capture, turn count and valids.
//  A stalled output holds its result while one more frame waits in stage one.

module motor_feedback_multiturn_tracker import mft_pkg::*; #(
  parameter int unsigned COUNTS_PER_TURN = 8192
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        in_payload_byte0,
  input  wire logic [7:0]        in_payload_byte1,
  input  wire logic [7:0]        in_payload_byte2,
  input  wire logic [7:0]        in_payload_byte3,
  input  wire logic [7:0]        in_payload_byte4,
  input  wire logic [7:0]        in_payload_byte5,
  input  wire logic [7:0]        in_payload_byte6,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [15:0]            out_position,
  output logic signed [15:0]     out_rotor_speed,
  output logic signed [15:0]     out_drive_current,
  output logic [7:0]             out_temperature,
  output logic signed [31:0]     out_turn_count,
  output logic signed [45:0]     out_total_angle
);

  localparam logic [PosW-1:0] Cpt = PosW'(COUNTS_PER_TURN);
  localparam int unsigned ProdW = TurnW + PosW + 1;

  logic   in_xfer, s1_adv;
  pos_t   in_pos;
  track_t trk;

  logic        s1_valid_r;
  pos_t        s1_pos_r;
  logic [15:0] s1_spd_r, s1_cur_r;
  logic [7:0]  s1_temp_r;
  track_t      s1_trk_r;

  logic        out_valid_r;
  pos_t        out_pos_r;
  logic [15:0] out_spd_r, out_cur_r;
  logic [7:0]  out_temp_r;
  turns_t      out_turns_r;
  angle_t      out_angle_r, angle_nxt;

  logic signed [ProdW-1:0] prod, sum;
  logic signed [PosW:0]    diff;

  assign in_pos   = {in_payload_byte0, in_payload_byte1};
  assign s1_adv   = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_xfer  = in_valid && in_ready;

  mft_unwrap #(
    .COUNTS_PER_TURN(COUNTS_PER_TURN)
  ) u_unwrap (
    .clk  (clk),
    .rst_n(rst_n),
    .en   (in_xfer),
    .pos  (in_pos),
    .trk  (trk)
  );

  assign prod = $signed({{(ProdW-TurnW){s1_trk_r.turns[TurnW-1]}}, s1_trk_r.turns})
              * $signed({{(ProdW-PosW){1'b0}}, Cpt});
  assign diff = $signed({1'b0, s1_pos_r}) - $signed({1'b0, s1_trk_r.zero_offset});
  assign sum  = prod + $signed({{(ProdW-PosW-1){diff[PosW]}}, diff});
  assign angle_nxt = sum[AngleW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_pos_r  <= in_pos;
      s1_spd_r  <= {in_payload_byte2, in_payload_byte3};
      s1_cur_r  <= {in_payload_byte4, in_payload_byte5};
      s1_temp_r <= in_payload_byte6;
      s1_trk_r  <= trk;
    end
    if (s1_adv && s1_valid_r) begin
      out_pos_r   <= s1_pos_r;
      out_spd_r   <= s1_spd_r;
      out_cur_r   <= s1_cur_r;
      out_temp_r  <= s1_temp_r;
      out_turns_r <= s1_trk_r.turns;
      out_angle_r <= angle_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_position      = out_pos_r;
  assign out_rotor_speed   = $signed(out_spd_r);
  assign out_drive_current = $signed(out_cur_r);
  assign out_temperature   = out_temp_r;
  assign out_turn_count    = out_turns_r;
  assign out_total_angle   = out_angle_r;

  // A full first stage behind a stalled output must hold off new frames.
  `MFT_ASSERT_SAME(a_stall_blocks_input, s1_valid_r && !s1_adv, !in_ready)
  // Every transfer lands in the first stage.
  `MFT_ASSERT_NEXT(a_xfer_fills_s1, in_xfer, s1_valid_r)
  // A taken result with nothing behind it leaves the output empty.
  `MFT_ASSERT_NEXT(a_drain_empties_out, out_valid_r && out_ready && !s1_valid_r, !out_valid_r)

endmodule

`default_nettype wire

/* verif/tb_motor_feedback_multiturn_tracker.sv */
`timescale 1ns / 1ps

module tb_motor_feedback_multiturn_tracker import mft_pkg::*;;

  localparam int unsigned COUNTS_PER_TURN = 8192;
  localparam int HALF_TURN = COUNTS_PER_TURN / 2;
  localparam int RANDOM_FRAMES = 1500;
  localparam int LONG_HOLD_CYCLES = 300;

  typedef logic [6:0][7:0] frame_t;

  typedef struct packed {
    pos_t               position;
    logic signed [15:0] rotor_speed;
    logic signed [15:0] drive_current;
    logic [7:0]         temperature;
    turns_t             turn_count;
    angle_t             total_angle;
  } reading_t;

  // Tracks the turn count of the frames that went in and holds the readings
  // they should produce, oldest first.
  class turn_track_board;
    pos_t     prev_pos;
    pos_t     zero_off;
    bit       captured;
    turns_t   turns;
    reading_t expected_readings[$];
    int       failures;

    function new();
      prev_pos = '0;
      zero_off = '0;
      captured = 1'b0;
      turns = '0;
      failures = 0;
    endfunction

    function void note_frame(frame_t f);
      reading_t r;
      int step;
      logic signed [63:0] turns_wide;
      logic signed [63:0] angle_wide;
      r.position = {f[0], f[1]};
      r.rotor_speed = {f[2], f[3]};
      r.drive_current = {f[4], f[5]};
      r.temperature = f[6];
      if (!captured) begin
        zero_off = r.position;
        captured = 1'b1;
      end else begin
        step = int'(r.position) - int'(prev_pos);
        if (step > HALF_TURN) turns = turns - 1;
        if (step < -HALF_TURN) turns = turns + 1;
      end
      prev_pos = r.position;
      turns_wide = turns;
      angle_wide = turns_wide * $signed(64'(COUNTS_PER_TURN)) + $signed({48'd0, r.position})
                   - $signed({48'd0, zero_off});
      r.turn_count = turns;
      r.total_angle = angle_wide[AngleW-1:0];
      expected_readings.push_back(r);
    endfunction

    function void compare_field(string name, logic signed [63:0] want,
                                logic signed [63:0] got);
      if (want !== got) begin
        if (failures < 10)
          $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
        failures++;
      end
    endfunction

    function void check_reading(reading_t got);
      reading_t want;
      if (expected_readings.size() == 0) begin
        if (failures < 10)
          $display("%0t: unexpected reading, position %0d angle %0d", $realtime,
                   got.position, got.total_angle);
        failures++;
        return;
      end
      want = expected_readings.pop_front();
      compare_field("position", want.position, got.position);
      compare_field("rotor_speed", want.rotor_speed, got.rotor_speed);
      compare_field("drive_current", want.drive_current, got.drive_current);
      compare_field("temperature", want.temperature, got.temperature);
      compare_field("turn_count", want.turn_count, got.turn_count);
      compare_field("total_angle", want.total_angle, got.total_angle);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_payload_byte0 = '0;
  logic [7:0] in_payload_byte1 = '0;
  logic [7:0] in_payload_byte2 = '0;
  logic [7:0] in_payload_byte3 = '0;
  logic [7:0] in_payload_byte4 = '0;
  logic [7:0] in_payload_byte5 = '0;
  logic [7:0] in_payload_byte6 = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [15:0] out_position;
  logic signed [15:0] out_rotor_speed;
  logic signed [15:0] out_drive_current;
  logic [7:0] out_temperature;
  logic signed [31:0] out_turn_count;
  logic signed [45:0] out_total_angle;

  bit quiet_phase = 1'b0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;

  turn_track_board board;

  motor_feedback_multiturn_tracker #(
    .COUNTS_PER_TURN(COUNTS_PER_TURN)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_payload_byte0(in_payload_byte0),
    .in_payload_byte1(in_payload_byte1),
    .in_payload_byte2(in_payload_byte2),
    .in_payload_byte3(in_payload_byte3),
    .in_payload_byte4(in_payload_byte4),
    .in_payload_byte5(in_payload_byte5),
    .in_payload_byte6(in_payload_byte6),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_position(out_position),
    .out_rotor_speed(out_rotor_speed),
    .out_drive_current(out_drive_current),
    .out_temperature(out_temperature),
    .out_turn_count(out_turn_count),
    .out_total_angle(out_total_angle)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic frame_t make_frame(int pos, logic [15:0] spd, logic [15:0] cur,
                                        logic [7:0] temp);
    frame_t f;
    f[0] = pos[15:8];
    f[1] = pos[7:0];
    f[2] = spd[15:8];
    f[3] = spd[7:0];
    f[4] = cur[15:8];
    f[5] = cur[7:0];
    f[6] = temp;
    return f;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_frame(frame_t f);
    while (!quiet_phase && $urandom_range(0, 99) < 6) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_payload_byte0 <= f[0];
    in_payload_byte1 <= f[1];
    in_payload_byte2 <= f[2];
    in_payload_byte3 <= f[3];
    in_payload_byte4 <= f[4];
    in_payload_byte5 <= f[5];
    in_payload_byte6 <= f[6];
    do @(posedge clk); while (!in_ready);
    board.note_frame(f);
    @(negedge clk);
  endtask

  // Receiver side: random back-pressure plus one long hold-off on request.
  always @(negedge clk) begin
    if (hold_req && !hold_done) begin
      hold_left = LONG_HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (quiet_phase) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= 6);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check_reading({out_position, out_rotor_speed, out_drive_current,
                           out_temperature, out_turn_count, out_total_angle});
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int dir_pos[23] = '{1000, 5096, 1000, 5097, 1000, 8191, 0, 8191, 65535, 0, 65535,
                        32768, 0, 4096, 0, 4097, 0, 8000, 100, 4196, 8191, 50, 50};
    logic [15:0] edge16[6] = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h5555, 16'hAAAA};
    logic [7:0] edge8[4] = '{8'h00, 8'hFF, 8'h55, 8'hAA};
    int last_pos;
    int pos;
    int delta;
    int sel;
    int guard;
    board = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed frames: offset capture, steps of exactly half a turn, steps just
    // past half a turn both ways, positions at or above one turn, word extremes.
    for (int k = 0; k < 23; k++)
      send_frame(make_frame(dir_pos[k], edge16[k % 6], edge16[(k + 3) % 6], edge8[k % 4]));
    last_pos = dir_pos[22];

    for (int k = 0; k < RANDOM_FRAMES; k++) begin
      if (k == 300) hold_req = 1'b1;
      quiet_phase = (k >= 700 && k < 1000);
      if (k == 1200) begin
        // Let the pipeline run dry before continuing.
        in_valid <= 1'b0;
        @(negedge clk);
        while (board.expected_readings.size() != 0) @(negedge clk);
      end
      sel = $urandom_range(0, 99);
      delta = 0;
      if (sel < 45) begin
        delta = int'($urandom_range(0, 400)) - 200;
      end else if (sel < 65) begin
        delta = int'($urandom_range(0, 8000)) - 4000;
      end else if (sel < 80) begin
        delta = int'($urandom_range(0, 16)) - 8;
        delta += $urandom_range(0, 1) ? HALF_TURN : -HALF_TURN;
      end
      if (sel < 80) begin
        pos = ((last_pos % COUNTS_PER_TURN + delta) % COUNTS_PER_TURN + COUNTS_PER_TURN)
              % COUNTS_PER_TURN;
      end else if (sel < 90) begin
        pos = $urandom_range(0, 65535);
      end else begin
        case ($urandom_range(0, 3))
          0: pos = 0;
          1: pos = COUNTS_PER_TURN - 1;
          2: pos = HALF_TURN;
          default: pos = COUNTS_PER_TURN;
        endcase
      end
      last_pos = pos;
      send_frame(make_frame(pos, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                            8'($urandom_range(0, 255))));
    end
    in_valid <= 1'b0;

    guard = 0;
    while (board.expected_readings.size() != 0 && guard < 100000) begin
      @(negedge clk);
      guard++;
    end
    repeat (10) @(negedge clk);

    if (board.failures == 0 && board.expected_readings.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
